// ===== rtl/sgr_pkg.sv =====
// ----------------------------------------------------------------------------
// SGR style parser package
// Shared types, character and SGR code constants for the style parser.
// ----------------------------------------------------------------------------
package sgr_pkg;

	localparam int MAX_ELEMENTS = 16;
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam logic [CNT_W:0] MAX_EL_V = (CNT_W + 1)'(MAX_ELEMENTS);

	localparam int ACC_W = 9;
	localparam logic [ACC_W-1:0] ACC_MAX = 9'd511;

	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_M        = 8'h6D;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG = 1'b1;

	localparam logic [7:0] DFLT_FG_RST = 8'd7;
	localparam logic [7:0] DFLT_BG_RST = 8'd0;

	localparam logic [1:0] BLINK_OFF   = 2'd0;
	localparam logic [1:0] BLINK_SLOW  = 2'd1;
	localparam logic [1:0] BLINK_RAPID = 2'd2;

	localparam logic KIND_CHAR  = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	localparam logic [7:0] BRIGHT_BASE = 8'd8;

	localparam logic [ACC_W-1:0] SGR_RESET        = 9'd0;
	localparam logic [ACC_W-1:0] SGR_BOLD         = 9'd1;
	localparam logic [ACC_W-1:0] SGR_UNDERLINE    = 9'd4;
	localparam logic [ACC_W-1:0] SGR_BLINK_SLOW   = 9'd5;
	localparam logic [ACC_W-1:0] SGR_BLINK_RAPID  = 9'd6;
	localparam logic [ACC_W-1:0] SGR_INVERT       = 9'd7;
	localparam logic [ACC_W-1:0] SGR_STRIKE       = 9'd9;
	localparam logic [ACC_W-1:0] SGR_FRAKTUR      = 9'd20;
	localparam logic [ACC_W-1:0] SGR_BOLD_OFF     = 9'd22;
	localparam logic [ACC_W-1:0] SGR_UNDERLINE_OFF = 9'd24;
	localparam logic [ACC_W-1:0] SGR_BLINK_OFF    = 9'd25;
	localparam logic [ACC_W-1:0] SGR_INVERT_OFF   = 9'd27;
	localparam logic [ACC_W-1:0] SGR_STRIKE_OFF   = 9'd29;
	localparam logic [ACC_W-1:0] SGR_FG_EXT       = 9'd38;
	localparam logic [ACC_W-1:0] SGR_FG_DEFAULT   = 9'd39;
	localparam logic [ACC_W-1:0] SGR_BG_EXT       = 9'd48;
	localparam logic [ACC_W-1:0] SGR_BG_DEFAULT   = 9'd49;
	localparam logic [ACC_W-1:0] SGR_EXT_PALETTE  = 9'd5;
	localparam logic [ACC_W-1:0] SGR_FG_DIM_LO    = 9'd30;
	localparam logic [ACC_W-1:0] SGR_FG_DIM_HI    = 9'd37;
	localparam logic [ACC_W-1:0] SGR_BG_DIM_LO    = 9'd40;
	localparam logic [ACC_W-1:0] SGR_BG_DIM_HI    = 9'd47;
	localparam logic [ACC_W-1:0] SGR_FG_BRIGHT_LO = 9'd90;
	localparam logic [ACC_W-1:0] SGR_FG_BRIGHT_HI = 9'd97;
	localparam logic [ACC_W-1:0] SGR_BG_BRIGHT_LO = 9'd100;
	localparam logic [ACC_W-1:0] SGR_BG_BRIGHT_HI = 9'd107;

	typedef enum logic [2:0] {
		PH_TEXT = 3'b001,
		PH_ESC  = 3'b010,
		PH_CSI  = 3'b100
	} phase_t;

	typedef enum logic [5:0] {
		EXT_NONE  = 6'b000001,
		EXT_FG5   = 6'b000010,
		EXT_FGIDX = 6'b000100,
		EXT_BG5   = 6'b001000,
		EXT_BGIDX = 6'b010000,
		EXT_FAIL  = 6'b100000
	} ext_t;

	typedef struct packed {
		logic [7:0] fg;
		logic [7:0] bg;
		logic       bold;
		logic       underline;
		logic       strike;
		logic       fraktur;
		logic       invert;
		logic [1:0] blink;
	} style_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] char_byte;
		style_t     style;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} res_push_t;

	function automatic style_t default_style(input logic [7:0] fg, input logic [7:0] bg);
		style_t s;
		s.fg        = fg;
		s.bg        = bg;
		s.bold      = 1'b0;
		s.underline = 1'b0;
		s.strike    = 1'b0;
		s.fraktur   = 1'b0;
		s.invert    = 1'b0;
		s.blink     = BLINK_OFF;
		return s;
	endfunction

endpackage

// ===== rtl/sgr_text_if.sv =====
// ----------------------------------------------------------------------------
// SGR text byte channel
// Valid/ready channel that carries one text byte per item.
// ----------------------------------------------------------------------------
interface sgr_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

// ===== rtl/sgr_result_if.sv =====
// ----------------------------------------------------------------------------
// SGR result channel
// Valid/ready channel that carries one styled character or error per item.
// ----------------------------------------------------------------------------
interface sgr_result_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_byte;
	logic [7:0] fg_index;
	logic [7:0] bg_index;
	logic       bold_on;
	logic       underline_on;
	logic       strike_on;
	logic       fraktur_on;
	logic       invert_on;
	logic [1:0] blink_mode;

	modport source (
		output valid, output kind, output char_byte, output fg_index, output bg_index,
		output bold_on, output underline_on, output strike_on, output fraktur_on,
		output invert_on, output blink_mode, input ready
	);
	modport sink (
		input valid, input kind, input char_byte, input fg_index, input bg_index,
		input bold_on, input underline_on, input strike_on, input fraktur_on,
		input invert_on, input blink_mode, output ready
	);
endinterface

// ===== rtl/sgr_core.sv =====
// ----------------------------------------------------------------------------
// SGR parser core
// Input byte register, escape sequence parse state and style registers, with
// the combinational update logic that handles one byte.
// ----------------------------------------------------------------------------
module sgr_core (
	input  logic                 clk,
	input  logic                 arst_n,
	sgr_text_if.sink             text,
	input  logic [7:0]           dflt_fg,
	input  logic [7:0]           dflt_bg,
	input  logic                 space,
	output sgr_pkg::res_push_t   push
);

	typedef struct packed {
		sgr_pkg::ext_t   ext;
		sgr_pkg::style_t style;
	} apply_t;

	function automatic apply_t apply_code(
		input logic [sgr_pkg::ACC_W-1:0] code,
		input sgr_pkg::ext_t             ext,
		input sgr_pkg::style_t           w,
		input logic [7:0]                dfg,
		input logic [7:0]                dbg
	);
		apply_t r;
		r.ext   = ext;
		r.style = w;
		if (ext == sgr_pkg::EXT_FG5 || ext == sgr_pkg::EXT_BG5) begin
			if (code == sgr_pkg::SGR_EXT_PALETTE) begin
				r.ext = (ext == sgr_pkg::EXT_FG5) ? sgr_pkg::EXT_FGIDX : sgr_pkg::EXT_BGIDX;
			end else begin
				r.ext = sgr_pkg::EXT_FAIL;
			end
		end else if (ext == sgr_pkg::EXT_FGIDX || ext == sgr_pkg::EXT_BGIDX) begin
			if (code[sgr_pkg::ACC_W-1]) begin
				r.ext = sgr_pkg::EXT_FAIL;
			end else begin
				if (ext == sgr_pkg::EXT_FGIDX) begin
					r.style.fg = code[7:0];
				end else begin
					r.style.bg = code[7:0];
				end
				r.ext = sgr_pkg::EXT_NONE;
			end
		end else if (ext == sgr_pkg::EXT_NONE) begin
			if (code >= sgr_pkg::SGR_FG_DIM_LO && code <= sgr_pkg::SGR_FG_DIM_HI) begin
				r.style.fg = 8'(code - sgr_pkg::SGR_FG_DIM_LO);
			end else if (code >= sgr_pkg::SGR_BG_DIM_LO && code <= sgr_pkg::SGR_BG_DIM_HI) begin
				r.style.bg = 8'(code - sgr_pkg::SGR_BG_DIM_LO);
			end else if (code >= sgr_pkg::SGR_FG_BRIGHT_LO
					&& code <= sgr_pkg::SGR_FG_BRIGHT_HI) begin
				r.style.fg = 8'(code - sgr_pkg::SGR_FG_BRIGHT_LO) + sgr_pkg::BRIGHT_BASE;
			end else if (code >= sgr_pkg::SGR_BG_BRIGHT_LO
					&& code <= sgr_pkg::SGR_BG_BRIGHT_HI) begin
				r.style.bg = 8'(code - sgr_pkg::SGR_BG_BRIGHT_LO) + sgr_pkg::BRIGHT_BASE;
			end else begin
				unique case (code)
					sgr_pkg::SGR_RESET:         r.style = sgr_pkg::default_style(dfg, dbg);
					sgr_pkg::SGR_BOLD:          r.style.bold = 1'b1;
					sgr_pkg::SGR_UNDERLINE:     r.style.underline = 1'b1;
					sgr_pkg::SGR_BLINK_SLOW:    r.style.blink = sgr_pkg::BLINK_SLOW;
					sgr_pkg::SGR_BLINK_RAPID:   r.style.blink = sgr_pkg::BLINK_RAPID;
					sgr_pkg::SGR_INVERT:        r.style.invert = 1'b1;
					sgr_pkg::SGR_STRIKE:        r.style.strike = 1'b1;
					sgr_pkg::SGR_FRAKTUR:       r.style.fraktur = 1'b1;
					sgr_pkg::SGR_BOLD_OFF:      r.style.bold = 1'b0;
					sgr_pkg::SGR_UNDERLINE_OFF: r.style.underline = 1'b0;
					sgr_pkg::SGR_BLINK_OFF:     r.style.blink = sgr_pkg::BLINK_OFF;
					sgr_pkg::SGR_INVERT_OFF:    r.style.invert = 1'b0;
					sgr_pkg::SGR_STRIKE_OFF:    r.style.strike = 1'b0;
					sgr_pkg::SGR_FG_EXT:        r.ext = sgr_pkg::EXT_FG5;
					sgr_pkg::SGR_FG_DEFAULT:    r.style.fg = dfg;
					sgr_pkg::SGR_BG_EXT:        r.ext = sgr_pkg::EXT_BG5;
					sgr_pkg::SGR_BG_DEFAULT:    r.style.bg = dbg;
					default:                    r.ext = sgr_pkg::EXT_FAIL;
				endcase
			end
		end
		return r;
	endfunction

	logic                       valid_s1;
	logic [7:0]                 byte_s1;
	sgr_pkg::phase_t            phase_q, phase_n;
	logic [sgr_pkg::ACC_W-1:0]  acc_q, acc_n;
	logic                       seen_q, seen_n;
	logic [sgr_pkg::CNT_W-1:0]  cnt_q, cnt_n;
	sgr_pkg::ext_t              ext_q, ext_n;
	sgr_pkg::style_t            comm_q, comm_n;
	sgr_pkg::style_t            work_q, work_n;

	logic                       emit;
	logic                       kind;
	logic [7:0]                 ch;
	logic                       do_fail;
	logic                       advance;
	logic                       accept;
	logic [12:0]                acc_prod;
	logic                       el_full;
	apply_t                     applied;

	assign acc_prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {9'b0, byte_s1[3:0]};
	assign el_full  = ({1'b0, cnt_q} + 1'b1) >= sgr_pkg::MAX_EL_V;
	assign applied  = apply_code(acc_q, ext_q, work_q, dflt_fg, dflt_bg);

	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		seen_n  = seen_q;
		cnt_n   = cnt_q;
		ext_n   = ext_q;
		comm_n  = comm_q;
		work_n  = work_q;
		emit    = 1'b0;
		kind    = sgr_pkg::KIND_CHAR;
		ch      = byte_s1;
		do_fail = 1'b0;
		if (byte_s1 == sgr_pkg::CH_NUL) begin
			emit    = (phase_q != sgr_pkg::PH_TEXT);
			kind    = sgr_pkg::KIND_ERROR;
			ch      = sgr_pkg::CH_NUL;
			phase_n = sgr_pkg::PH_TEXT;
			acc_n   = '0;
			seen_n  = 1'b0;
			cnt_n   = '0;
			ext_n   = sgr_pkg::EXT_NONE;
			comm_n  = sgr_pkg::default_style(dflt_fg, dflt_bg);
			work_n  = sgr_pkg::default_style(dflt_fg, dflt_bg);
		end else begin
			unique case (phase_q)
				sgr_pkg::PH_TEXT: begin
					if (byte_s1 == sgr_pkg::CH_ESC) begin
						work_n  = comm_q;
						phase_n = sgr_pkg::PH_ESC;
					end else begin
						emit = 1'b1;
					end
				end
				sgr_pkg::PH_ESC: begin
					if (byte_s1 != sgr_pkg::CH_LBRACKET) begin
						do_fail = 1'b1;
					end else begin
						phase_n = sgr_pkg::PH_CSI;
						acc_n   = '0;
						seen_n  = 1'b0;
						cnt_n   = '0;
						ext_n   = sgr_pkg::EXT_NONE;
					end
				end
				sgr_pkg::PH_CSI: begin
					priority if (byte_s1 >= sgr_pkg::CH_ZERO && byte_s1 <= sgr_pkg::CH_NINE) begin
						acc_n  = (acc_prod > 13'(sgr_pkg::ACC_MAX)) ? sgr_pkg::ACC_MAX
							: acc_prod[sgr_pkg::ACC_W-1:0];
						seen_n = 1'b1;
					end else if (byte_s1 == sgr_pkg::CH_SEMI) begin
						if (!seen_q || el_full) begin
							do_fail = 1'b1;
						end else begin
							ext_n  = applied.ext;
							work_n = applied.style;
							cnt_n  = cnt_q + 1'b1;
							acc_n  = '0;
							seen_n = 1'b0;
						end
					end else if (byte_s1 == sgr_pkg::CH_M) begin
						if (!seen_q || applied.ext != sgr_pkg::EXT_NONE) begin
							do_fail = 1'b1;
						end else begin
							comm_n  = applied.style;
							work_n  = applied.style;
							phase_n = sgr_pkg::PH_TEXT;
							acc_n   = '0;
							seen_n  = 1'b0;
							cnt_n   = '0;
							ext_n   = sgr_pkg::EXT_NONE;
						end
					end else begin
						do_fail = 1'b1;
					end
				end
				default: begin
					phase_n = sgr_pkg::PH_TEXT;
				end
			endcase
			if (do_fail) begin
				work_n  = comm_q;
				phase_n = sgr_pkg::PH_TEXT;
				acc_n   = '0;
				seen_n  = 1'b0;
				cnt_n   = '0;
				ext_n   = sgr_pkg::EXT_NONE;
				emit    = 1'b1;
				kind    = sgr_pkg::KIND_ERROR;
				ch      = sgr_pkg::CH_NUL;
			end
		end
	end

	assign advance    = valid_s1 && (!emit || space);
	assign text.ready = !valid_s1 || advance;
	assign accept     = text.valid && text.ready;

	assign push.valid          = advance && emit;
	assign push.data.kind      = kind;
	assign push.data.char_byte = ch;
	assign push.data.style     = comm_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text.text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sgr_pkg::PH_TEXT;
			acc_q   <= '0;
			seen_q  <= 1'b0;
			cnt_q   <= '0;
			ext_q   <= sgr_pkg::EXT_NONE;
			comm_q  <= sgr_pkg::default_style(sgr_pkg::DFLT_FG_RST, sgr_pkg::DFLT_BG_RST);
			work_q  <= sgr_pkg::default_style(sgr_pkg::DFLT_FG_RST, sgr_pkg::DFLT_BG_RST);
		end else if (advance) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			seen_q  <= seen_n;
			cnt_q   <= cnt_n;
			ext_q   <= ext_n;
			comm_q  <= comm_n;
			work_q  <= work_n;
		end
	end

	a_text_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == sgr_pkg::PH_TEXT |-> ext_q == sgr_pkg::EXT_NONE && cnt_q == '0 && !seen_q)
		else $error("parse state not clean in text phase");

	a_style_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(comm_q) && $stable(work_q))
		else $error("style changed without a byte being handled");

	a_nul_reset: assert property (@(posedge clk) disable iff (!arst_n)
		advance && byte_s1 == sgr_pkg::CH_NUL |=> phase_q == sgr_pkg::PH_TEXT && work_q == comm_q)
		else $error("end of string did not reset the parser");

	a_char_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && push.data.kind == sgr_pkg::KIND_CHAR |-> phase_q == sgr_pkg::PH_TEXT)
		else $error("character item produced inside a sequence");

endmodule

// ===== rtl/sgr_outq.sv =====
// ----------------------------------------------------------------------------
// SGR result queue
// Two-entry output queue that decouples the parser from result backpressure.
// ----------------------------------------------------------------------------
module sgr_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  sgr_pkg::res_push_t  push,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output sgr_pkg::result_t    out_data
);

	sgr_pkg::result_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign space     = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push.valid) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> cnt_q != 2'd2)
		else $error("item pushed into a full result queue");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("result queue count did not follow a push");

endmodule

// ===== rtl/ansi_sgr_style_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ANSI SGR style parser
// Tracks SGR escape sequences in a text byte stream and tags each character
// byte with the current text style.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle at full rate: each byte is
// registered and handled by a combinational parse and style update, and
// any result it causes enters a two-entry output queue. Bytes that cause
// no result (ESC, the bracket, parameter bytes, a successful final m, a
// zero byte in text) are absorbed without an output item. The input stalls
// only while the output queue is full and the byte waiting in the input
// register produces a result. The default color registers take effect at
// the next code 0, 39, 49 or zero byte.
module ansi_sgr_style_parser_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sgr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                      cfg_wdata,
	sgr_text_if.sink                        text,
	sgr_result_if.source                    result
);

	logic [7:0]         dflt_fg_q;
	logic [7:0]         dflt_bg_q;
	logic               space;
	sgr_pkg::res_push_t push;
	sgr_pkg::result_t   out_data;
	logic               out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_fg_q <= sgr_pkg::DFLT_FG_RST;
			dflt_bg_q <= sgr_pkg::DFLT_BG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sgr_pkg::CFG_DEFAULT_FG: dflt_fg_q <= cfg_wdata;
				sgr_pkg::CFG_DEFAULT_BG: dflt_bg_q <= cfg_wdata;
			endcase
		end
	end

	sgr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text),
		.dflt_fg (dflt_fg_q),
		.dflt_bg (dflt_bg_q),
		.space   (space),
		.push    (push)
	);

	sgr_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.out_data  (out_data)
	);

	assign result.valid        = out_valid;
	assign result.kind         = out_data.kind;
	assign result.char_byte    = out_data.char_byte;
	assign result.fg_index     = out_data.style.fg;
	assign result.bg_index     = out_data.style.bg;
	assign result.bold_on      = out_data.style.bold;
	assign result.underline_on = out_data.style.underline;
	assign result.strike_on    = out_data.style.strike;
	assign result.fraktur_on   = out_data.style.fraktur;
	assign result.invert_on    = out_data.style.invert;
	assign result.blink_mode   = out_data.style.blink;

endmodule
